// File: src/tcc_pkg.sv
package tcc_pkg;

  localparam int unsigned FirstPrintable = 32;
  localparam int unsigned LastPrintable  = 126;
  localparam int unsigned TabStop        = 8;
  localparam int unsigned TabShift       = $clog2(TabStop);

  localparam logic [2:0] OpPut         = 3'd0;
  localparam logic [2:0] OpClearScreen = 3'd1;
  localparam logic [2:0] OpHome        = 3'd2;
  localparam logic [2:0] OpEnd         = 3'd3;
  localparam logic [2:0] OpScrollUp    = 3'd4;

  localparam logic [2:0] CmdGlyph       = 3'd0;
  localparam logic [2:0] CmdClearCell   = 3'd1;
  localparam logic [2:0] CmdScroll      = 3'd2;
  localparam logic [2:0] CmdClearScreen = 3'd3;
  localparam logic [2:0] CmdCursor      = 3'd4;

  localparam logic [7:0] CharBackspace = 8'd8;
  localparam logic [7:0] CharTab       = 8'd9;
  localparam logic [7:0] CharNewline   = 8'd10;
  localparam logic [7:0] CharReturn    = 8'd13;

  localparam logic [1:0] RegEnable  = 2'd0;
  localparam logic [1:0] RegColumns = 2'd1;
  localparam logic [1:0] RegRows    = 2'd2;
  localparam logic [1:0] RegTheme   = 2'd3;

  localparam logic [9:0] ColumnsReset = 10'd80;
  localparam logic [8:0] RowsReset    = 9'd25;
  localparam logic [9:0] MaxColumns   = 10'd512;
  localparam logic [8:0] MaxRows      = 9'd256;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [5:0] line_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [8:0]  cell_col;
    logic [7:0]  cell_row;
    logic [6:0]  glyph_index;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [8:0]  cursor_col_now;
    logic [7:0]  cursor_row_now;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       enable;
    logic [9:0] columns;
    logic [8:0] rows_in_use;
    logic [2:0] theme;
  } cfg_t;

  typedef struct packed {
    out_item_t  first;
    logic [5:0] extra;
    logic [8:0] col;
    logic [7:0] row;
  } plan_t;

  function automatic logic [23:0] pal_fg(input logic [2:0] t);
    logic [23:0] c;
    unique case (t)
      3'd0:    c = 24'hFFFFFF;
      3'd1:    c = 24'hE0E0E0;
      3'd2:    c = 24'h000000;
      3'd3:    c = 24'h00FF00;
      3'd4:    c = 24'h00FFFF;
      3'd5:    c = 24'h90EE90;
      3'd6:    c = 24'h87CEEB;
      default: c = 24'hFFD700;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] pal_bg(input logic [2:0] t);
    logic [23:0] c;
    unique case (t)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'h1E1E1E;
      3'd2:    c = 24'hFFFFFF;
      3'd3:    c = 24'h000000;
      3'd4:    c = 24'h0A0A1A;
      3'd5:    c = 24'h0D1F0D;
      3'd6:    c = 24'h0A1628;
      default: c = 24'h1A0A00;
    endcase
    return c;
  endfunction

endpackage

// File: src/tcc_exec.sv
module tcc_exec (
  input  tcc_pkg::in_item_t item_i,
  input  tcc_pkg::cfg_t     cfg_i,
  input  logic [8:0]        col_i,
  input  logic [7:0]        row_i,
  output tcc_pkg::plan_t    plan_o
);
  import tcc_pkg::*;

  logic [9:0] ecols;
  logic [8:0] erows;
  logic [8:0] row_inc;
  logic       nl_scroll;
  logic [7:0] nl_row;
  logic [9:0] col_inc;
  logic [9:0] tab_x;
  logic [6:0] glyph;

  logic [8:0] col_d;
  logic [7:0] row_d;
  logic [2:0] cmd;
  logic [8:0] cc;
  logic [7:0] cr;
  logic [6:0] gi;
  logic [5:0] extra;

  always_comb begin
    if (cfg_i.columns == 10'd0) begin
      ecols = 10'd1;
    end else if (cfg_i.columns > MaxColumns) begin
      ecols = MaxColumns;
    end else begin
      ecols = cfg_i.columns;
    end
    if (cfg_i.rows_in_use == 9'd0) begin
      erows = 9'd1;
    end else if (cfg_i.rows_in_use > MaxRows) begin
      erows = MaxRows;
    end else begin
      erows = cfg_i.rows_in_use;
    end
  end

  assign row_inc   = {1'b0, row_i} + 9'd1;
  assign nl_scroll = (row_inc >= erows);
  assign nl_row    = nl_scroll ? 8'(erows - 9'd1) : row_inc[7:0];
  assign col_inc   = {1'b0, col_i} + 10'd1;
  assign tab_x     = 10'(((({1'b0, col_i}) >> TabShift) + 10'd1) << TabShift);
  assign glyph     = ((item_i.char_code >= 8'(FirstPrintable)) &&
                      (item_i.char_code <= 8'(LastPrintable))) ?
                     7'(item_i.char_code - 8'(FirstPrintable)) : 7'd0;

  always_comb begin
    col_d = col_i;
    row_d = row_i;
    cmd   = CmdCursor;
    cc    = 9'd0;
    cr    = 8'd0;
    gi    = 7'd0;
    extra = 6'd0;
    unique case (item_i.opcode)
      OpPut: begin
        if (cfg_i.enable) begin
          unique case (item_i.char_code)
            CharNewline: begin
              col_d = 9'd0;
              row_d = nl_row;
              if (nl_scroll) begin
                cmd = CmdScroll;
              end
            end
            CharReturn: begin
              col_d = 9'd0;
            end
            CharBackspace: begin
              if (col_i != 9'd0) begin
                col_d = col_i - 9'd1;
              end else if (row_i != 8'd0) begin
                row_d = row_i - 8'd1;
                col_d = 9'(ecols - 10'd1);
              end
              cmd = CmdClearCell;
              cc  = col_d;
              cr  = row_d;
            end
            CharTab: begin
              if (tab_x >= ecols) begin
                col_d = 9'd0;
                row_d = nl_row;
                if (nl_scroll) begin
                  cmd = CmdScroll;
                end
              end else begin
                col_d = tab_x[8:0];
              end
            end
            default: begin
              cmd = CmdGlyph;
              cc  = col_i;
              cr  = row_i;
              gi  = glyph;
              if (col_inc >= ecols) begin
                col_d = 9'd0;
                row_d = nl_row;
                if (nl_scroll) begin
                  extra = 6'd1;
                end
              end else begin
                col_d = col_inc[8:0];
              end
            end
          endcase
        end
      end
      OpClearScreen: begin
        if (cfg_i.enable) begin
          cmd   = CmdClearScreen;
          col_d = 9'd0;
          row_d = 8'd0;
        end
      end
      OpHome: begin
        col_d = 9'd0;
        row_d = 8'd0;
      end
      OpEnd: begin
        col_d = 9'(ecols - 10'd1);
        row_d = 8'(erows - 9'd1);
      end
      OpScrollUp: begin
        if (cfg_i.enable && (item_i.line_count != 6'd0)) begin
          cmd   = CmdScroll;
          extra = item_i.line_count - 6'd1;
        end
      end
      default: begin
        cmd = CmdCursor;
      end
    endcase
  end

  always_comb begin
    plan_o.first.command        = cmd;
    plan_o.first.cell_col       = cc;
    plan_o.first.cell_row       = cr;
    plan_o.first.glyph_index    = gi;
    plan_o.first.fg_color       = pal_fg(cfg_i.theme);
    plan_o.first.bg_color       = pal_bg(cfg_i.theme);
    plan_o.first.cursor_col_now = col_d;
    plan_o.first.cursor_row_now = row_d;
    plan_o.first.last           = (extra == 6'd0);
    plan_o.extra                = extra;
    plan_o.col                  = col_d;
    plan_o.row                  = row_d;
  end

endmodule

// File: src/tcc_out.sv
module tcc_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tcc_pkg::plan_t      plan_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcc_pkg::out_item_t  out_data_o
);
  import tcc_pkg::*;

  logic       valid_q;
  logic       valid_d;
  logic [5:0] extra_q;
  logic [5:0] extra_d;
  out_item_t  data_q;
  out_item_t  data_d;
  logic       pop;

  assign pop    = valid_q && out_ready_i;
  assign free_o = !valid_q || (out_ready_i && (extra_q == 6'd0));

  always_comb begin
    valid_d = valid_q;
    extra_d = extra_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      extra_d = plan_i.extra;
      data_d  = plan_i.first;
    end else if (pop) begin
      if (extra_q != 6'd0) begin
        extra_d            = extra_q - 6'd1;
        data_d.command     = CmdScroll;
        data_d.cell_col    = 9'd0;
        data_d.cell_row    = 8'd0;
        data_d.glyph_index = 7'd0;
        data_d.last        = (extra_q == 6'd1);
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      extra_q <= 6'd0;
    end else begin
      valid_q <= valid_d;
      extra_q <= extra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: src/text_console_cursor_controller.sv
// Each item passes the input register and then the output register to reach the output.
// One item per cycle unless stalled; an item with n results keeps the output until all go.
// An input register and an output register with a scroll repeat counter part the sides.
// Reset is asynchronous and active low: valids clear, the cursor goes to row 0, column 0,
// and the registers return to disabled, 80 columns, 25 rows and theme 0.
module text_console_cursor_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i
);
  import tcc_pkg::*;

  logic     in_valid_q;
  in_item_t in_q;
  cfg_t     cfg_q;
  logic [8:0] col_q;
  logic [7:0] row_q;
  plan_t    plan;
  logic     free;
  logic     advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && free;
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= 1'b0;
      cfg_q.columns     <= ColumnsReset;
      cfg_q.rows_in_use <= RowsReset;
      cfg_q.theme       <= 3'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEnable:  cfg_q.enable      <= cfg_data_i[0];
        RegColumns: cfg_q.columns     <= cfg_data_i;
        RegRows:    cfg_q.rows_in_use <= cfg_data_i[8:0];
        RegTheme:   cfg_q.theme       <= cfg_data_i[2:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      col_q      <= 9'd0;
      row_q      <= 8'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        col_q <= plan.col;
        row_q <= plan.row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  tcc_exec u_exec (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .col_i  (col_q),
    .row_i  (row_q),
    .plan_o (plan)
  );

  tcc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .plan_i      (plan),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/tcc_checker.sv
module tcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tcc_pkg::out_item_t out_data_o
);
  import tcc_pkg::*;

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Every result after the first of an item is a scroll that follows at once.
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && (out_data_o.command == CmdScroll))
    else $error("missing follow-on scroll");

  // All results of one item report the same cursor and background color.
  a_same_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      (out_data_o.cursor_col_now == $past(out_data_o.cursor_col_now)) &&
      (out_data_o.cursor_row_now == $past(out_data_o.cursor_row_now)) &&
      (out_data_o.bg_color == $past(out_data_o.bg_color)))
    else $error("results of one item disagree");

  // Only cell commands carry a cell position or a glyph.
  a_cell_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.command != CmdGlyph) &&
      (out_data_o.command != CmdClearCell) |->
      (out_data_o.cell_col == 9'd0) && (out_data_o.cell_row == 8'd0) &&
      (out_data_o.glyph_index == 7'd0))
    else $error("cell fields set on a non-cell command");

endmodule

bind text_console_cursor_controller tcc_checker u_tcc_checker (.*);

// File: tb/sv/tb_top.sv
module tb_top;
  import tcc_pkg::*;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SegItems   = 45;
  localparam logic [2:0]  OpUnusedLo = 3'd5;
  localparam logic [2:0]  OpUnusedHi = 3'd7;

  class console_scoreboard;
    logic        enable;
    logic [9:0]  columns;
    logic [8:0]  rows;
    logic [2:0]  theme;
    int unsigned cur_col;
    int unsigned cur_row;
    logic [23:0] fg_pal [8];
    logic [23:0] bg_pal [8];
    out_item_t   draw_cmds[$];
    out_item_t   expected_q[$];
    int unsigned errors;

    function new();
      fg_pal = '{24'hFFFFFF, 24'hE0E0E0, 24'h000000, 24'h00FF00,
                 24'h00FFFF, 24'h90EE90, 24'h87CEEB, 24'hFFD700};
      bg_pal = '{24'h000000, 24'h1E1E1E, 24'hFFFFFF, 24'h000000,
                 24'h0A0A1A, 24'h0D1F0D, 24'h0A1628, 24'h1A0A00};
      enable  = 1'b0;
      columns = ColumnsReset;
      rows    = RowsReset;
      theme   = 3'd0;
      cur_col = 0;
      cur_row = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        RegEnable:  enable  = val[0];
        RegColumns: columns = val;
        RegRows:    rows    = val[8:0];
        RegTheme:   theme   = val[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned cols_eff();
      if (columns == 0) return 1;
      return (columns > MaxColumns) ? MaxColumns : columns;
    endfunction

    function int unsigned rows_eff();
      if (rows == 0) return 1;
      return (rows > MaxRows) ? MaxRows : rows;
    endfunction

    function void add_draw(logic [2:0] cmd, int unsigned col, int unsigned row,
                           int unsigned glyph);
      out_item_t r;
      r = '0;
      r.command     = cmd;
      r.cell_col    = 9'(col);
      r.cell_row    = 8'(row);
      r.glyph_index = 7'(glyph);
      if (draw_cmds.size() < 63) draw_cmds.push_back(r);
    endfunction

    function void line_feed();
      int unsigned r;
      r = cur_row + 1;
      cur_col = 0;
      if (r >= rows_eff()) begin
        add_draw(CmdScroll, 0, 0, 0);
        r = rows_eff() - 1;
      end
      cur_row = r & 8'hFF;
    endfunction

    function void put_char(logic [7:0] c);
      int unsigned cols;
      int unsigned x;
      int unsigned g;
      cols = cols_eff();
      case (c)
        CharNewline: line_feed();
        CharReturn:  cur_col = 0;
        CharBackspace: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = cols - 1;
          end
          add_draw(CmdClearCell, cur_col, cur_row, 0);
        end
        CharTab: begin
          x = cur_col + TabStop;
          x -= x % TabStop;
          if (x >= cols) line_feed();
          else cur_col = x;
        end
        default: begin
          g = (c >= FirstPrintable && c <= LastPrintable) ? c - FirstPrintable : 0;
          add_draw(CmdGlyph, cur_col, cur_row, g);
          x = cur_col + 1;
          if (x >= cols) line_feed();
          else cur_col = x;
        end
      endcase
    endfunction

    function void note_item(in_item_t it);
      draw_cmds.delete();
      case (it.opcode)
        OpPut: if (enable) put_char(it.char_code);
        OpClearScreen: if (enable) begin
          add_draw(CmdClearScreen, 0, 0, 0);
          cur_col = 0;
          cur_row = 0;
        end
        OpHome: begin
          cur_col = 0;
          cur_row = 0;
        end
        OpEnd: begin
          cur_col = (cols_eff() - 1) & 9'h1FF;
          cur_row = (rows_eff() - 1) & 8'hFF;
        end
        OpScrollUp: if (enable) begin
          for (int i = 0; i < it.line_count; i++) add_draw(CmdScroll, 0, 0, 0);
        end
        default: ;
      endcase
      if (draw_cmds.size() == 0) add_draw(CmdCursor, 0, 0, 0);
      foreach (draw_cmds[k]) begin
        draw_cmds[k].fg_color       = fg_pal[theme];
        draw_cmds[k].bg_color       = bg_pal[theme];
        draw_cmds[k].cursor_col_now = 9'(cur_col);
        draw_cmds[k].cursor_row_now = 8'(cur_row);
        draw_cmds[k].last           = (k == draw_cmds.size() - 1);
        expected_q.push_back(draw_cmds[k]);
      end
    endfunction

    function void cmp(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp("command", want.command, got.command);
      cmp("cell_col", want.cell_col, got.cell_col);
      cmp("cell_row", want.cell_row, got.cell_row);
      cmp("glyph_index", want.glyph_index, got.glyph_index);
      cmp("fg_color", want.fg_color, got.fg_color);
      cmp("bg_color", want.bg_color, got.bg_color);
      cmp("cursor_col_now", want.cursor_col_now, got.cursor_col_now);
      cmp("cursor_row_now", want.cursor_row_now, got.cursor_row_now);
      cmp("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  console_scoreboard sb;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;

  text_console_cursor_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t make_item(logic [2:0] op, logic [7:0] ch, logic [5:0] n);
    in_item_t it;
    it.opcode     = op;
    it.char_code  = ch;
    it.line_count = n;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    it.opcode     = OpPut;
    it.char_code  = 8'($urandom);
    it.line_count = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 62) begin
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(3))
            0: it.char_code = CharBackspace;
            1: it.char_code = CharTab;
            2: it.char_code = CharNewline;
            default: it.char_code = CharReturn;
          endcase
        end
        1, 2: it.char_code = 8'($urandom_range(FirstPrintable, LastPrintable));
        default: ;
      endcase
    end else if (pick < 65) begin
      it.opcode = OpClearScreen;
    end else if (pick < 71) begin
      it.opcode = OpHome;
    end else if (pick < 79) begin
      it.opcode = OpEnd;
    end else if (pick < 94) begin
      it.opcode = OpScrollUp;
      if ($urandom_range(9) != 0) it.line_count = 6'($urandom_range(3));
    end else begin
      it.opcode = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    in_item_t    directed[$];
    logic [9:0]  cols_set [8];
    logic [8:0]  rows_set [8];
    int unsigned seg;
    sb = new();
    cols_set = '{10'd8, 10'd1, 10'd0, 10'd512, 10'd1023, 10'd80, 10'd13, 10'd20};
    rows_set = '{9'd3, 9'd1, 9'd256, 9'd0, 9'd511, 9'd25, 9'd2, 9'd5};
    cols_set[7] = 10'($urandom_range(1, 40));
    rows_set[7] = 9'($urandom_range(1, 10));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // While disabled only home and end move the cursor; end parks it at the corner.
    directed = '{make_item(OpPut, "A", 6'd0), make_item(OpClearScreen, 8'd0, 6'd0),
                 make_item(OpScrollUp, 8'd0, 6'd3), make_item(OpEnd, 8'd0, 6'd0),
                 make_item(OpUnusedLo, 8'hFF, 6'h3F)};
    foreach (directed[i]) send_item(directed[i]);
    drain_block();
    write_reg(RegEnable, 10'd1);

    directed = '{make_item(OpPut, "Z", 6'd0), make_item(OpPut, CharNewline, 6'd0),
                 make_item(OpHome, 8'd0, 6'd0), make_item(OpPut, CharBackspace, 6'd0),
                 make_item(OpPut, 8'h20, 6'd0), make_item(OpPut, 8'h7E, 6'd0),
                 make_item(OpPut, 8'h7F, 6'd0), make_item(OpPut, 8'h00, 6'd0),
                 make_item(OpPut, 8'hFF, 6'd0), make_item(OpPut, CharTab, 6'd0),
                 make_item(OpPut, CharReturn, 6'd0), make_item(OpPut, CharNewline, 6'd0),
                 make_item(OpPut, CharBackspace, 6'd0), make_item(OpPut, CharTab, 6'd0),
                 make_item(OpClearScreen, 8'd0, 6'd0), make_item(OpScrollUp, 8'd0, 6'd0),
                 make_item(OpScrollUp, 8'd0, 6'd63), make_item(OpUnusedHi, 8'd0, 6'd0),
                 make_item(OpEnd, 8'd0, 6'd0), make_item(OpPut, CharBackspace, 6'd0)};
    foreach (directed[i]) send_item(directed[i]);
    drain_block();

    // Shrinking the screen leaves the cursor outside it; the next glyph wraps and scrolls.
    write_reg(RegColumns, 10'd8);
    write_reg(RegRows, 10'd2);
    send_item(make_item(OpPut, "q", 6'd0));
    drain_block();

    for (seg = 0; seg < 8; seg++) begin
      write_reg(RegEnable, (seg == 6) ? 10'd0 : 10'd1);
      write_reg(RegColumns, cols_set[seg]);
      write_reg(RegRows, {1'b0, rows_set[seg]});
      write_reg(RegTheme, 10'(seg));
      case (seg % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          sender_idle_pct = 20;
          stall_pct = 20;
        end
      endcase
      for (int n = 0; n < SegItems; n++) begin
        if (seg == 0 && n == 5) holds_asked <= holds_asked + 1;
        send_item(rand_item());
      end
      drain_block();
    end

    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
